// ===== design/lcmf_pkg.sv =====
// Shared constants and types for the line and corner mask filter.
`default_nettype none

package lcmf_pkg;

	// The window is five pixels square and the line store keeps four earlier rows.
	localparam int WIN = 5;
	localparam int LINES = 4;

	// Masks for the rows and columns of the window that lie inside the frame.
	typedef struct packed {
		logic [WIN-1:0] row_ok;
		logic [WIN-1:0] col_ok;
	} lcmf_mask_t;

endpackage

`default_nettype wire

// ===== design/lcmf_line_store.sv =====
// Line store: four rows of pixel sums per column, read, modified and written back.
`default_nettype none

module lcmf_line_store import lcmf_pkg::*; #(
	parameter int PIX_BITS = 22,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH),
	localparam int SB = $clog2(LINES)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          issue,
	input  logic [AW-1:0]                 issue_addr,
	input  logic [SB-1:0]                 issue_slot,
	input  logic [PIX_BITS-1:0]           issue_pix,
	input  logic                          commit,
	output logic [WIN-1:0][PIX_BITS-1:0]  col
);

	logic [LINES-1:0][PIX_BITS-1:0] mem [DEPTH];
	logic [LINES-1:0][PIX_BITS-1:0] rd_s1;
	logic [LINES-1:0][PIX_BITS-1:0] fwd_s1;
	logic [LINES-1:0][PIX_BITS-1:0] cur;
	logic [LINES-1:0][PIX_BITS-1:0] wr;
	logic [AW-1:0]                  addr_s1;
	logic [SB-1:0]                  slot_s1;
	logic [PIX_BITS-1:0]            pix_s1;
	logic                           fwd_v_s1;

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_s1 <= mem[issue_addr];
		end
		if (commit) begin
			mem[addr_s1] <= wr;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			addr_s1 <= issue_addr;
			slot_s1 <= issue_slot;
			pix_s1  <= issue_pix;
			fwd_s1  <= wr;
		end
	end

	// A read of the column that is being written in the same cycle takes the new word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_s1 <= 1'b0;
		end else if (issue) begin
			fwd_v_s1 <= commit && (addr_s1 == issue_addr);
		end
	end

	assign cur = fwd_v_s1 ? fwd_s1 : rd_s1;

	// The slot of the current row holds the row four above until it is overwritten.
	always_comb begin
		wr = cur;
		wr[slot_s1] = pix_s1;
		for (int y = 0; y < LINES; y++) begin
			col[y] = cur[slot_s1 + SB'(y)];
		end
		col[WIN-1] = pix_s1;
	end

endmodule

`default_nettype wire

// ===== design/lcmf_window.sv =====
// Five by five pixel window with zero padding and the six mask sums.
`default_nettype none

module lcmf_window import lcmf_pkg::*; #(
	parameter int PIX_BITS = 22,
	localparam int SUM_BITS = PIX_BITS + 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          shift,
	input  logic [WIN-1:0][PIX_BITS-1:0]  col,
	input  lcmf_mask_t                    mask,
	output logic signed [SUM_BITS-1:0]    horizontal_sum,
	output logic signed [SUM_BITS-1:0]    vertical_sum,
	output logic signed [SUM_BITS-1:0]    left_below_sum,
	output logic signed [SUM_BITS-1:0]    right_below_sum,
	output logic signed [SUM_BITS-1:0]    left_above_sum,
	output logic signed [SUM_BITS-1:0]    right_above_sum
);

	logic [WIN-1:0][WIN-1:0][PIX_BITS-1:0] win_q;
	logic [WIN-1:0][WIN-1:0][PIX_BITS-1:0] win_n;
	logic signed [SUM_BITS-1:0]            m [WIN][WIN];

	always_comb begin
		for (int y = 0; y < WIN; y++) begin
			for (int x = 0; x < WIN - 1; x++) begin
				win_n[y][x] = win_q[y][x+1];
			end
			win_n[y][WIN-1] = col[y];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (shift) begin
			win_q <= win_n;
		end
	end

	always_comb begin
		for (int y = 0; y < WIN; y++) begin
			for (int x = 0; x < WIN; x++) begin
				if (mask.row_ok[y] && mask.col_ok[x]) begin
					m[y][x] = SUM_BITS'($signed(win_n[y][x]));
				end else begin
					m[y][x] = '0;
				end
			end
		end
	end

	assign horizontal_sum  = m[2][0] + m[2][1] + m[2][2] + m[2][3] + m[2][4];
	assign vertical_sum    = m[0][2] + m[1][2] + m[2][2] + m[3][2] + m[4][2];
	assign left_below_sum  = m[1][1] + m[2][1] + m[3][1] + m[3][2] + m[3][3];
	assign right_below_sum = m[1][3] + m[2][3] + m[3][3] + m[3][1] + m[3][2];
	assign left_above_sum  = m[1][1] + m[2][1] + m[3][1] + m[1][2] + m[1][3];
	assign right_above_sum = m[1][3] + m[2][3] + m[3][3] + m[1][1] + m[1][2];

endmodule

`default_nettype wire

// ===== design/line_corner_mask_filter_core.sv =====
// Line and corner mask filter: six zero-padded window sums for every pixel of a raster frame.
// Throughput is one word per cycle per stream unless stalled; a pixel takes channel_count words.
// A result passes stage one and the output register after the word that completes the pixel
// two rows and two pixels on. A register write holds s_tready low through ST_MUL, ST_ADD and ST_DIV
// while a multiplier and a bit-serial divider rebuild the positions for the new frame size.
// Reset clears counters and window and sets the registers to their defaults at once; the line store is left as it is.
`default_nettype none

module line_corner_mask_filter_core import lcmf_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_CHANNELS = 64,
	parameter int SAMPLE_BITS = 16,
	localparam int IN_W = 8 * ((SAMPLE_BITS + 7) / 8),
	localparam int PIX_BITS = SAMPLE_BITS + $clog2(MAX_CHANNELS),
	localparam int SUM_BITS = PIX_BITS + 3,
	localparam int OUT_W = 8 * ((6 * SUM_BITS + 7) / 8)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,   // sample
	input  logic              s_tuser,   // op: 0 channel sample, 1 drain tick
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // horizontal, vertical, left_below, right_below,
	                                     // left_above, right_above sums
	output logic              m_tlast    // frame_end
);

	localparam int FW_BITS = 11;
	localparam int CC_BITS = 7;
	localparam int WB = $clog2(MAX_WIDTH + 1);
	localparam int HB = $clog2(MAX_HEIGHT + 1);
	localparam int CB = $clog2(MAX_CHANNELS + 1);
	localparam int COL_BITS = $clog2(MAX_WIDTH);
	localparam int OPOS_BITS = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int IR_BITS = OPOS_BITS + 1;
	localparam int P_BITS = IR_BITS + WB;
	localparam int WH_BITS = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int CP_BITS = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int SB = $clog2(LINES);
	localparam int DC_BITS = $clog2(OPOS_BITS);
	localparam int RST_W = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
	localparam int RST_H = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;
	localparam int RST_WH = RST_W * RST_H;

	localparam logic [1:0] REG_WIDTH    = 2'd0;
	localparam logic [1:0] REG_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_CHANNELS = 2'd2;

	localparam logic [1:0] ST_RUN = 2'd0;
	localparam logic [1:0] ST_MUL = 2'd1;
	localparam logic [1:0] ST_ADD = 2'd2;
	localparam logic [1:0] ST_DIV = 2'd3;

	logic [FW_BITS-1:0] fw_q;
	logic [FW_BITS-1:0] fh_q;
	logic [CC_BITS-1:0] cc_q;
	logic [WB-1:0]      w_c;
	logic [HB-1:0]      h_c;
	logic [CB-1:0]      c_c;
	logic               cfg_wr;
	logic [1:0]         cfg_idx;

	logic [1:0]                state_q;
	logic signed [PIX_BITS-1:0] acc_q;
	logic [CP_BITS-1:0]        cpos_q;
	logic [COL_BITS-1:0]       ic_q;
	logic [IR_BITS-1:0]        ir_q;
	logic [P_BITS-1:0]         p_q;
	logic [P_BITS-1:0]         prod_q;
	logic [OPOS_BITS-1:0]      opos_q;
	logic [OPOS_BITS-1:0]      orow_q;
	logic [COL_BITS-1:0]       ocol_q;
	logic [WH_BITS-1:0]        wh_q;
	logic [WB-1:0]             div_rem_q;
	logic [OPOS_BITS-1:0]      div_quo_q;
	logic [DC_BITS-1:0]        div_cnt_q;
	logic [WB:0]               rem_sh;
	logic                      div_ge;
	logic [WB-1:0]             rem_nx;
	logic [OPOS_BITS-1:0]      quo_nx;

	logic                      fire;
	logic                      op;
	logic                      draining;
	logic                      last_ch;
	logic                      adv;
	logic                      emit;
	logic                      col_wrap;
	logic                      ocol_wrap;
	logic                      fend;
	logic signed [PIX_BITS-1:0] acc_sum;
	logic [PIX_BITS-1:0]       pix_v;
	lcmf_mask_t                mask;

	logic                      vld_s1;
	logic                      emit_s1;
	logic                      fend_s1;
	lcmf_mask_t                mask_s1;
	logic                      s1_go;
	logic                      commit;

	logic                      out_v_q;
	logic                      out_last_q;
	logic signed [SUM_BITS-1:0] hs_q, vs_q, lb_q, rb_q, la_q, ra_q;
	logic signed [SUM_BITS-1:0] hs, vs, lb, rb, la, ra;
	logic [WIN-1:0][PIX_BITS-1:0] col;

	// Configuration port.
	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FW_BITS'(640);
			fh_q <= FW_BITS'(480);
			cc_q <= CC_BITS'(3);
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_WIDTH:    fw_q <= pwdata[FW_BITS-1:0];
				REG_HEIGHT:   fh_q <= pwdata[FW_BITS-1:0];
				REG_CHANNELS: cc_q <= pwdata[CC_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_WIDTH:    prdata = 32'(fw_q);
			REG_HEIGHT:   prdata = 32'(fh_q);
			REG_CHANNELS: prdata = 32'(cc_q);
			default:      prdata = '0;
		endcase
	end

	// Register values in use are held to their legal ranges.
	always_comb begin
		if (fw_q == '0) begin
			w_c = WB'(1);
		end else if (32'(fw_q) > MAX_WIDTH) begin
			w_c = WB'(MAX_WIDTH);
		end else begin
			w_c = WB'(fw_q);
		end
		if (fh_q == '0) begin
			h_c = HB'(1);
		end else if (32'(fh_q) > MAX_HEIGHT) begin
			h_c = HB'(MAX_HEIGHT);
		end else begin
			h_c = HB'(fh_q);
		end
		if (cc_q == '0) begin
			c_c = CB'(1);
		end else if (32'(cc_q) > MAX_CHANNELS) begin
			c_c = CB'(MAX_CHANNELS);
		end else begin
			c_c = CB'(cc_q);
		end
	end

	// One restoring division step: output position over width.
	assign rem_sh = {div_rem_q, div_quo_q[OPOS_BITS-1]};
	assign div_ge = rem_sh >= {1'b0, w_c};
	assign rem_nx = div_ge ? WB'(rem_sh - {1'b0, w_c}) : WB'(rem_sh);
	assign quo_nx = {div_quo_q[OPOS_BITS-2:0], div_ge};

	// Input side decisions.
	assign s1_go    = !vld_s1 || !emit_s1 || !out_v_q || m_tready;
	assign commit   = vld_s1 && s1_go;
	assign s_tready = (state_q == ST_RUN) && s1_go;
	assign fire     = s_tvalid && s_tready;
	assign op       = s_tuser;
	assign draining = 32'(ir_q) >= 32'(h_c);
	assign acc_sum  = acc_q + PIX_BITS'($signed(s_tdata[SAMPLE_BITS-1:0]));
	assign last_ch  = (32'(cpos_q) + 32'd1) >= 32'(c_c);
	assign adv      = fire && ((!op && !draining && last_ch) || (op && draining));
	assign pix_v    = op ? '0 : acc_sum;
	assign emit     = 64'(p_q) >= ((64'(w_c) << 1) + 64'd2);
	assign col_wrap = (32'(ic_q) + 32'd1) >= 32'(w_c);
	assign ocol_wrap = (32'(ocol_q) + 32'd1) >= 32'(w_c);
	assign fend     = (32'(opos_q) + 32'd1) >= 32'(wh_q);

	// A window row or column counts when its frame coordinate lies inside the frame.
	always_comb begin
		for (int k = 0; k < WIN; k++) begin
			mask.row_ok[k] = ((32'(orow_q) + k) >= 2) && ((32'(orow_q) + k) < (32'(h_c) + 2));
			mask.col_ok[k] = ((32'(ocol_q) + k) >= 2) && ((32'(ocol_q) + k) < (32'(w_c) + 2));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_RUN;
			acc_q     <= '0;
			cpos_q    <= '0;
			ic_q      <= '0;
			ir_q      <= '0;
			p_q       <= '0;
			prod_q    <= '0;
			opos_q    <= '0;
			orow_q    <= '0;
			ocol_q    <= '0;
			wh_q      <= WH_BITS'(RST_WH);
			div_rem_q <= '0;
			div_quo_q <= '0;
			div_cnt_q <= '0;
		end else begin
			// After a register write the positions are rebuilt for the new frame size.
			if (cfg_wr && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT ||
					cfg_idx == REG_CHANNELS)) begin
				state_q <= ST_MUL;
			end else begin
				case (state_q)
					ST_RUN: ;
					ST_MUL: begin
						prod_q  <= P_BITS'(ir_q) * P_BITS'(w_c);
						wh_q    <= WH_BITS'(w_c) * WH_BITS'(h_c);
						state_q <= ST_ADD;
					end
					ST_ADD: begin
						p_q       <= prod_q + P_BITS'(ic_q);
						div_rem_q <= '0;
						div_quo_q <= opos_q;
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end
					ST_DIV: begin
						div_rem_q <= rem_nx;
						div_quo_q <= quo_nx;
						div_cnt_q <= div_cnt_q + 1'b1;
						if (div_cnt_q == DC_BITS'(OPOS_BITS - 1)) begin
							orow_q  <= quo_nx;
							ocol_q  <= COL_BITS'(rem_nx);
							state_q <= ST_RUN;
						end
					end
					default: state_q <= ST_RUN;
				endcase
			end

			if (fire && !op && !draining) begin
				if (last_ch) begin
					acc_q  <= '0;
					cpos_q <= '0;
				end else begin
					acc_q  <= acc_sum;
					cpos_q <= cpos_q + 1'b1;
				end
			end

			if (adv) begin
				if (col_wrap) begin
					ic_q <= '0;
					ir_q <= ir_q + 1'b1;
					p_q  <= p_q - P_BITS'(ic_q) + P_BITS'(w_c);
				end else begin
					ic_q <= ic_q + 1'b1;
					p_q  <= p_q + 1'b1;
				end
				if (emit) begin
					if (fend) begin
						acc_q  <= '0;
						cpos_q <= '0;
						ic_q   <= '0;
						ir_q   <= '0;
						p_q    <= '0;
						opos_q <= '0;
						orow_q <= '0;
						ocol_q <= '0;
					end else begin
						opos_q <= opos_q + 1'b1;
						if (ocol_wrap) begin
							ocol_q <= '0;
							orow_q <= orow_q + 1'b1;
						end else begin
							ocol_q <= ocol_q + 1'b1;
						end
					end
				end
			end
		end
	end

	// Stage one: line store read data arrives and the window shifts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			emit_s1 <= 1'b0;
		end else if (s1_go) begin
			vld_s1  <= adv;
			emit_s1 <= adv && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mask_s1 <= mask;
			fend_s1 <= fend;
		end
	end

	lcmf_line_store #(
		.PIX_BITS (PIX_BITS),
		.DEPTH    (MAX_WIDTH)
	) u_line_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.issue      (adv),
		.issue_addr (ic_q),
		.issue_slot (ir_q[SB-1:0]),
		.issue_pix  (pix_v),
		.commit     (commit),
		.col        (col)
	);

	lcmf_window #(
		.PIX_BITS (PIX_BITS)
	) u_window (
		.clk             (clk),
		.arst_n          (arst_n),
		.shift           (commit),
		.col             (col),
		.mask            (mask_s1),
		.horizontal_sum  (hs),
		.vertical_sum    (vs),
		.left_below_sum  (lb),
		.right_below_sum (rb),
		.left_above_sum  (la),
		.right_above_sum (ra)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (commit && emit_s1) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && emit_s1) begin
			hs_q       <= hs;
			vs_q       <= vs;
			lb_q       <= lb;
			rb_q       <= rb;
			la_q       <= la;
			ra_q       <= ra;
			out_last_q <= fend_s1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tlast  = out_last_q;

	always_comb begin
		m_tdata = '0;
		m_tdata[6*SUM_BITS-1:0] = {ra_q, la_q, rb_q, lb_q, vs_q, hs_q};
	end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the line and corner mask filter core.
`timescale 1ns / 100ps

module tb_top;
	import lcmf_pkg::*;

	localparam int MAX_W = 1024;
	localparam int MAX_H = 1024;
	localparam int MAX_C = 64;
	localparam int SUM_W = 25;
	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_WORDS = 360;

	typedef enum logic {OP_SAMPLE = 1'b0, OP_DRAIN = 1'b1} lcmf_op_e;
	typedef enum logic [1:0] {REG_WIDTH, REG_HEIGHT, REG_CHANNELS} lcmf_reg_e;
	typedef enum int {FLOW_FREE, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL, FLOW_BOTH} flow_e;
	typedef enum int {FILL_RANDOM, FILL_MIN, FILL_MAX} fill_e;

	typedef struct packed {
		lcmf_op_e    op;
		logic [15:0] value;
	} stream_word_t;

	typedef struct packed {
		logic                  frame_end;
		logic [5:0][SUM_W-1:0] sum;
	} window_sums_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [3:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [15:0]  s_tdata = '0;   // sample
	logic         s_tuser = 1'b0; // op
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [151:0] m_tdata;        // horizontal, vertical, left_below, right_below,
	                              // left_above, right_above sums, then zero padding
	logic         m_tlast;        // frame_end

	line_corner_mask_filter_core dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	string sum_name [6] = '{"horizontal_sum", "vertical_sum", "left_below_sum",
		"right_below_sum", "left_above_sum", "right_above_sum"};

	// Shadow registers and filter state.
	int cfg_width = 640;
	int cfg_height = 480;
	int cfg_chans = 3;
	int pix_acc, chan_pos, col_in, row_in, out_pos;
	int line_mem [LINES*MAX_W];
	int win [WIN][WIN];

	window_sums_t sums_due [$];
	stream_word_t word_queue [$];

	flow_e flow = FLOW_FREE;
	logic  hold_req = 1'b0;
	int    words_pushed, words_taken, stim_words, reg_writes;
	int    results_seen, frames_seen, mismatches, reg_errors, quiet_cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int clamp_reg(input int v, input int hi);
		return (v < 1) ? 1 : ((v > hi) ? hi : v);
	endfunction

	function automatic bit pause_now(input bit rx_side);
		int pct;
		if (flow == FLOW_BOTH)
			pct = 31;
		else if (rx_side ? (flow == FLOW_RECEIVER_STALL) : (flow == FLOW_SENDER_IDLE))
			pct = 69;
		else
			pct = 0;
		return $urandom_range(99) < pct;
	endfunction

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Computes the six window sums that one accepted word produces, if any.
	task automatic predict_window_sums(input lcmf_op_e op, input logic [15:0] raw);
		int w, h, c, pix, ic, orow, ocol, rr, cc;
		int col [WIN];
		int m [WIN][WIN];
		longint p;
		window_sums_t r;
		w = clamp_reg(cfg_width, MAX_W);
		h = clamp_reg(cfg_height, MAX_H);
		c = clamp_reg(cfg_chans, MAX_C);
		if (op == OP_SAMPLE) begin
			if (row_in >= h)
				return;
			pix_acc += int'($signed(raw));
			if (chan_pos + 1 < c) begin
				chan_pos++;
				return;
			end
			pix = pix_acc;
			pix_acc = 0;
			chan_pos = 0;
		end else begin
			if (row_in < h)
				return;
			pix = 0;
		end

		ic = (col_in >= MAX_W) ? MAX_W - 1 : col_in;
		for (int y = 0; y < LINES; y++)
			col[y] = line_mem[((row_in + y) % LINES) * MAX_W + ic];
		col[LINES] = pix;
		line_mem[(row_in % LINES) * MAX_W + ic] = pix;
		for (int y = 0; y < WIN; y++) begin
			for (int x = 0; x < WIN - 1; x++)
				win[y][x] = win[y][x+1];
			win[y][WIN-1] = col[y];
		end

		p = longint'(row_in) * w + col_in;
		if (col_in + 1 >= w) begin
			col_in = 0;
			row_in++;
		end else begin
			col_in++;
		end
		// The first two rows and two pixels only fill the window.
		if (p < 2 * w + 2)
			return;

		orow = out_pos / w;
		ocol = out_pos % w;
		for (int y = 0; y < WIN; y++)
			for (int x = 0; x < WIN; x++) begin
				rr = orow + y - 2;
				cc = ocol + x - 2;
				m[y][x] = (rr < 0 || rr >= h || cc < 0 || cc >= w) ? 0 : win[y][x];
			end

		r.sum[0] = SUM_W'(m[2][0] + m[2][1] + m[2][2] + m[2][3] + m[2][4]);
		r.sum[1] = SUM_W'(m[0][2] + m[1][2] + m[2][2] + m[3][2] + m[4][2]);
		r.sum[2] = SUM_W'(m[1][1] + m[2][1] + m[3][1] + m[3][2] + m[3][3]);
		r.sum[3] = SUM_W'(m[1][3] + m[2][3] + m[3][3] + m[3][1] + m[3][2]);
		r.sum[4] = SUM_W'(m[1][1] + m[2][1] + m[3][1] + m[1][2] + m[1][3]);
		r.sum[5] = SUM_W'(m[1][3] + m[2][3] + m[3][3] + m[1][1] + m[1][2]);
		r.frame_end = (longint'(out_pos) + 1 >= longint'(w) * h);
		if (r.frame_end) begin
			pix_acc = 0;
			chan_pos = 0;
			col_in = 0;
			row_in = 0;
			out_pos = 0;
		end else begin
			out_pos++;
		end
		sums_due.push_back(r);
	endtask

	always @(posedge clk) begin : sender
		stream_word_t next_word;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_window_sums(lcmf_op_e'(s_tuser), s_tdata);
				words_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (word_queue.size() != 0 && !pause_now(1'b0)) begin
					next_word = word_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_word.value;
					s_tuser <= next_word.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : receiver
		window_sums_t got, want;
		int hold_left;
		logic hold_seen;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left = 0;
			hold_seen = 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.sum = m_tdata[6*SUM_W-1:0];
				got.frame_end = m_tlast;
				results_seen++;
				if (got.frame_end)
					frames_seen++;
				if (sums_due.size() == 0) begin
					$error("result word arrived with no prediction pending");
					mismatches++;
				end else begin
					want = sums_due.pop_front();
					for (int k = 0; k < 6; k++)
						if (got.sum[k] !== want.sum[k]) begin
							$error("%s: expected %0d, got %0d", sum_name[k],
								$signed(want.sum[k]), $signed(got.sum[k]));
							mismatches++;
						end
					if (got.frame_end !== want.frame_end) begin
						$error("frame_end: expected %0b, got %0b", want.frame_end,
							got.frame_end);
						mismatches++;
					end
				end
			end
			// A toggle of hold_req starts one long hold-off on the output side.
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !pause_now(1'b1);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic reg_read(input lcmf_reg_e idx, input int unsigned want);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= 4'(int'(idx) * 4);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			$error("%s readback: expected %0d, got %0d", idx.name(), want, prdata);
			reg_errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic reg_write(input lcmf_reg_e idx, input int unsigned val);
		int unsigned kept;
		kept = (idx == REG_CHANNELS) ? (val & 'h7F) : (val & 'h7FF);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 4'(int'(idx) * 4);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_WIDTH: cfg_width = kept;
			REG_HEIGHT: cfg_height = kept;
			default: cfg_chans = kept;
		endcase
		reg_writes++;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		reg_read(idx, kept);
	endtask

	task automatic wait_idle();
		while (words_taken != words_pushed || sums_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_frame(input int unsigned w, input int unsigned h, input int unsigned c);
		wait_idle();
		reg_write(REG_WIDTH, w);
		reg_write(REG_HEIGHT, h);
		reg_write(REG_CHANNELS, c);
	endtask

	task automatic push_word(input lcmf_op_e op, input logic [15:0] value, input bit counted);
		word_queue.push_back('{op: op, value: value});
		words_pushed++;
		if (counted)
			stim_words++;
	endtask

	// One whole frame, with the odd ignored word mixed in: drain ticks while pixels
	// are still due and samples while the tail is being flushed.
	task automatic send_frame(input fill_e fill);
		int w, h, c;
		logic [15:0] v;
		w = clamp_reg(cfg_width, MAX_W);
		h = clamp_reg(cfg_height, MAX_H);
		c = clamp_reg(cfg_chans, MAX_C);
		for (int i = 0; i < w * h * c; i++) begin
			if ($urandom_range(24) == 0)
				push_word(OP_DRAIN, 16'($urandom), 1'b0);
			case (fill)
				FILL_MIN: v = 16'h8000;
				FILL_MAX: v = 16'h7FFF;
				default: v = pick_sample();
			endcase
			push_word(OP_SAMPLE, v, 1'b1);
		end
		for (int i = 0; i < 2 * w + 2; i++) begin
			if ($urandom_range(24) == 0)
				push_word(OP_SAMPLE, pick_sample(), 1'b0);
			push_word(OP_DRAIN, 16'($urandom), 1'b1);
		end
	endtask

	initial begin : stimulus
		logic [15:0] corner_vals [12];
		int phase_start;
		corner_vals = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h0000, 16'hFFFF,
			16'h5555, 16'hAAAA, 16'h0001, 16'h8001, 16'h7FFE, 16'h1234};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		reg_read(REG_WIDTH, 640);
		reg_read(REG_HEIGHT, 480);
		reg_read(REG_CHANNELS, 3);

		// Small hand-built frame: extreme samples, a drain tick before the frame is
		// complete and a sample during the flush, both of which must be ignored.
		set_frame(3, 2, 2);
		foreach (corner_vals[i]) begin
			push_word(OP_SAMPLE, corner_vals[i], 1'b1);
			if (i == 3)
				push_word(OP_DRAIN, 16'h0000, 1'b1);
		end
		push_word(OP_SAMPLE, 16'h7FFF, 1'b1);
		repeat (8) push_word(OP_DRAIN, 16'h0000, 1'b1);

		// Register extremes, with zero and oversized values that must clamp.
		set_frame(2047, 0, 0);
		send_frame(FILL_RANDOM);
		set_frame(1, 1024, 1);
		send_frame(FILL_RANDOM);
		set_frame(5, 1, 64);
		send_frame(FILL_MIN);
		set_frame(1, 5, 127);
		send_frame(FILL_MAX);

		// Size change in the middle of a frame. The full frame before it writes
		// every line store entry that the shrunken frame can reach.
		set_frame(6, 5, 2);
		send_frame(FILL_RANDOM);
		repeat (30) push_word(OP_SAMPLE, pick_sample(), 1'b1);
		set_frame(4, 3, 1);
		while (row_in != 0 || col_in != 0 || out_pos != 0) begin
			if (row_in >= clamp_reg(cfg_height, MAX_H))
				push_word(OP_DRAIN, 16'h0000, 1'b1);
			else
				repeat (clamp_reg(cfg_chans, MAX_C)) push_word(OP_SAMPLE, pick_sample(), 1'b1);
			while (words_taken != words_pushed)
				@(posedge clk);
		end

		for (int mode = 0; mode < 4; mode++) begin
			wait_idle();
			flow = flow_e'(mode);
			if (flow == FLOW_RECEIVER_STALL)
				hold_req <= !hold_req;
			phase_start = stim_words;
			while (stim_words - phase_start < PHASE_WORDS) begin
				set_frame($urandom_range(9) == 0 ? 0 : $urandom_range(1, 12),
					$urandom_range(9) == 0 ? 0 : $urandom_range(1, 6),
					$urandom_range(9) == 0 ? 0 : $urandom_range(1, 4));
				repeat ($urandom_range(1, 3)) send_frame(FILL_RANDOM);
			end
		end

		while (words_taken != words_pushed || sums_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d input words and %0d register writes; checked %0d result words in %0d frames.",
			words_taken, reg_writes, results_seen, frames_seen);
		$display("Covered clamped sizes, a mid-frame resize, full-scale sums and all idle patterns.");
		if (mismatches == 0 && reg_errors == 0 && sums_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
design/lcmf_pkg.sv
design/lcmf_line_store.sv
design/lcmf_window.sv
design/line_corner_mask_filter_core.sv
test/tb_top.sv
